FILE: rtl/msp_pkg.sv
// Package with shared constants, types and a function of the MIDI stream parser.
`default_nettype none
package msp_pkg;
   localparam int BUF_DEPTH = 32;
   localparam int ADDR_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] REG_RUNNING_STATUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PARAM_TRACKING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DISCARD_REPORT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LENGTH = 2'd3;

   localparam logic [1:0] KIND_MESSAGE = 2'd0;
   localparam logic [1:0] KIND_DISCARD = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   localparam logic [1:0] ACTION_SET = 2'd0;
   localparam logic [1:0] ACTION_INC = 2'd1;
   localparam logic [1:0] ACTION_DEC = 2'd2;

   localparam logic [7:0] CC_DATA_MSB = 8'd6;
   localparam logic [7:0] CC_DATA_LSB = 8'd38;
   localparam logic [7:0] CC_INC = 8'd96;
   localparam logic [7:0] CC_DEC = 8'd97;
   localparam logic [7:0] CC_NRPN_LSB = 8'd98;
   localparam logic [7:0] CC_NRPN_MSB = 8'd99;
   localparam logic [7:0] CC_RPN_LSB = 8'd100;
   localparam logic [7:0] CC_RPN_MSB = 8'd101;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END = 8'hF7;
   localparam logic [7:0] REALTIME_FIRST = 8'hF8;
   localparam logic [3:0] STATUS_CC = 4'hB;

   typedef enum logic [1:0] {
      CMD_SINGLE,
      CMD_RUN,
      CMD_EVENT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [1:0]       kind;
      logic [7:0]       byte_value;
      logic [CNT_W-1:0] count;
      logic [3:0]       event_channel;
      logic             event_type;
      logic [1:0]       event_action;
      logic [13:0]      event_parameter;
      logic [13:0]      event_value;
   } cmd_type;

   typedef struct packed {
      logic             read_en;
      logic [ADDR_W-1:0] read_addr;
   } buf_read_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_STORE,
      F_FINISH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_DATA
   } back_state_type;

   function automatic logic [1:0] needed_length(input logic [7:0] s);
      logic [1:0] n;
      n = 2'd0;
      if (s >= 8'h80 && s <= 8'hBF) n = 2'd3;
      else if (s >= 8'hC0 && s <= 8'hDF) n = 2'd2;
      else if (s >= 8'hE0 && s <= 8'hEF) n = 2'd3;
      else if (s == 8'hF1 || s == 8'hF3) n = 2'd2;
      else if (s == 8'hF2) n = 2'd3;
      else if (s == 8'hF6) n = 2'd1;
      return n;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/msp_cmd_fifo.sv
// Two-entry command queue between the parser front and the result back end.
`default_nettype none
module msp_cmd_fifo (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire msp_pkg::cmd_type push_cmd,
   input  wire logic            pop,
   output logic                 empty,
   output msp_pkg::cmd_type     head
);
   msp_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (pop && !empty) ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop && !empty};
   end

   assign empty = (count_ff == 2'd0);
   assign head = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("command queue overflow");
endmodule
`default_nettype wire

FILE: rtl/msp_front.sv
// Parser front end: framing, message buffer, parameter tracker and configuration registers.
`default_nettype none
module msp_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [7:0]                     data_byte,
   input  wire logic                           csr_write,
   input  wire logic [msp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [msp_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                           drained,
   output logic                                cmd_push,
   output msp_pkg::cmd_type                    cmd,
   input  wire msp_pkg::buf_read_type          rd_req,
   output logic [7:0]                          rd_data
);
   logic [7:0] mem [msp_pkg::BUF_DEPTH];
   logic [7:0] rd_data_ff;

   msp_pkg::front_state_type state_ff, state_in;
   logic [msp_pkg::CNT_W-1:0] held_ff, held_in;
   logic [msp_pkg::CNT_W-1:0] run_cnt_ff, run_cnt_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] buf0_ff, buf0_in;
   logic [7:0] buf1_ff, buf1_in;
   logic [1:0] phase_ff, phase_in;
   logic       pkind_ff, pkind_in;
   logic [3:0] pchan_ff, pchan_in;
   logic [13:0] pnum_ff, pnum_in;
   logic [13:0] pval_ff, pval_in;
   logic       rs_en_ff, trk_en_ff, disc_en_ff;
   logic [5:0] max_len_ff;

   logic       wr_en;
   logic [msp_pkg::ADDR_W-1:0] wr_addr;
   logic [7:0] wr_data;
   logic       accept;
   logic [msp_pkg::CNT_W-1:0] lim;
   logic [msp_pkg::CNT_W-1:0] held_next;
   logic [7:0] st0;
   logic [1:0] need;
   logic       complete;
   logic       can_store;
   logic [7:0] cc_num;
   logic       is_sel;
   logic       tracked;
   logic       sel_kind;
   logic [13:0] shifted;

   assign full = !(state_ff == msp_pkg::F_IDLE && drained);
   assign accept = push && !full;
   assign rd_data = rd_data_ff;

   always_comb begin
      if (max_len_ff > 6'(msp_pkg::BUF_DEPTH)) lim = msp_pkg::CNT_W'(msp_pkg::BUF_DEPTH);
      else if (max_len_ff < 6'd3) lim = msp_pkg::CNT_W'(3);
      else lim = msp_pkg::CNT_W'(max_len_ff);
   end

   always_comb begin
      can_store = held_ff < msp_pkg::CNT_W'(msp_pkg::BUF_DEPTH);
      held_next = can_store ? held_ff + 1'b1 : held_ff;
      st0 = (held_ff == '0) ? byte_ff : buf0_ff;
      need = msp_pkg::needed_length(st0);
      complete = (need != 2'd0) && (held_next == msp_pkg::CNT_W'(need));
      cc_num = buf1_ff;
      is_sel = cc_num == msp_pkg::CC_NRPN_MSB || cc_num == msp_pkg::CC_NRPN_LSB ||
               cc_num == msp_pkg::CC_RPN_MSB || cc_num == msp_pkg::CC_RPN_LSB;
      tracked = is_sel || cc_num == msp_pkg::CC_DATA_MSB || cc_num == msp_pkg::CC_DATA_LSB ||
                cc_num == msp_pkg::CC_INC || cc_num == msp_pkg::CC_DEC;
      sel_kind = cc_num == msp_pkg::CC_RPN_MSB || cc_num == msp_pkg::CC_RPN_LSB;
      if (cc_num == msp_pkg::CC_NRPN_MSB || cc_num == msp_pkg::CC_RPN_MSB ||
          cc_num == msp_pkg::CC_DATA_MSB) begin
         shifted = {byte_ff[6:0], 7'd0};
      end else begin
         shifted = {6'd0, byte_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      run_cnt_in = run_cnt_ff;
      byte_in = byte_ff;
      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      phase_in = phase_ff;
      pkind_in = pkind_ff;
      pchan_in = pchan_ff;
      pnum_in = pnum_ff;
      pval_in = pval_ff;
      wr_en = 1'b0;
      wr_addr = held_ff[msp_pkg::ADDR_W-1:0];
      wr_data = byte_ff;
      cmd_push = 1'b0;
      cmd = '0;
      cmd.op = msp_pkg::CMD_SINGLE;
      case (state_ff)
         msp_pkg::F_IDLE: begin
            if (accept) begin
               byte_in = data_byte;
               if (data_byte >= msp_pkg::REALTIME_FIRST) begin
                  cmd_push = 1'b1;
                  cmd.kind = msp_pkg::KIND_MESSAGE;
                  cmd.byte_value = data_byte;
               end else if (held_ff == '0 && !data_byte[7]) begin
                  if (rs_en_ff && buf0_ff >= 8'h80 && buf0_ff <= 8'hEF) begin
                     held_in = msp_pkg::CNT_W'(1);
                     state_in = msp_pkg::F_STORE;
                  end else if (disc_en_ff) begin
                     cmd_push = 1'b1;
                     cmd.kind = msp_pkg::KIND_DISCARD;
                     cmd.byte_value = data_byte;
                  end
               end else if (held_ff != '0 && data_byte[7]) begin
                  held_in = '0;
                  state_in = msp_pkg::F_STORE;
                  if (buf0_ff == msp_pkg::SYSEX_START) begin
                     wr_en = can_store;
                     wr_data = msp_pkg::SYSEX_END;
                     cmd_push = 1'b1;
                     cmd.op = msp_pkg::CMD_RUN;
                     cmd.kind = msp_pkg::KIND_MESSAGE;
                     cmd.count = held_next;
                     if (data_byte == msp_pkg::SYSEX_END) begin
                        state_in = msp_pkg::F_IDLE;
                     end
                  end else if (disc_en_ff) begin
                     cmd_push = 1'b1;
                     cmd.op = msp_pkg::CMD_RUN;
                     cmd.kind = msp_pkg::KIND_DISCARD;
                     cmd.count = held_ff;
                  end
               end else begin
                  state_in = msp_pkg::F_STORE;
               end
            end
         end
         msp_pkg::F_STORE: begin
            if (drained) begin
               wr_en = can_store;
               held_in = held_next;
               if (held_ff == '0) buf0_in = byte_ff;
               if (held_ff == msp_pkg::CNT_W'(1)) buf1_in = byte_ff;
               state_in = msp_pkg::F_IDLE;
               if (complete) begin
                  held_in = '0;
                  run_cnt_in = held_next;
                  cmd.op = msp_pkg::CMD_RUN;
                  cmd.kind = msp_pkg::KIND_MESSAGE;
                  cmd.count = held_next;
                  cmd_push = 1'b1;
                  if (trk_en_ff && st0[7:4] == msp_pkg::STATUS_CC && tracked) begin
                     cmd.op = msp_pkg::CMD_EVENT;
                     cmd.kind = msp_pkg::KIND_EVENT;
                     cmd.count = '0;
                     cmd.event_channel = pchan_ff;
                     cmd.event_type = pkind_ff;
                     cmd.event_parameter = pnum_ff;
                     cmd.event_value = {6'd0, byte_ff};
                     cmd_push = 1'b0;
                     state_in = msp_pkg::F_FINISH;
                     if (phase_ff == 2'd0) begin
                        if (is_sel) begin
                           pkind_in = sel_kind;
                           pchan_in = st0[3:0];
                           pnum_in = shifted;
                           phase_in = 2'd1;
                        end
                     end else if (pchan_ff != st0[3:0]) begin
                        phase_in = 2'd0;
                     end else if (phase_ff == 2'd1) begin
                        if (is_sel && sel_kind == pkind_ff) begin
                           pnum_in = pnum_ff | shifted;
                           phase_in = 2'd2;
                        end else begin
                           phase_in = 2'd0;
                        end
                     end else if (phase_ff == 2'd2) begin
                        phase_in = 2'd0;
                        if (cc_num == msp_pkg::CC_DATA_MSB || cc_num == msp_pkg::CC_DATA_LSB) begin
                           pval_in = shifted;
                           phase_in = 2'd3;
                        end else if (cc_num == msp_pkg::CC_INC) begin
                           cmd_push = 1'b1;
                           cmd.event_action = msp_pkg::ACTION_INC;
                        end else if (cc_num == msp_pkg::CC_DEC) begin
                           cmd_push = 1'b1;
                           cmd.event_action = msp_pkg::ACTION_DEC;
                        end
                     end else begin
                        phase_in = 2'd0;
                        if (cc_num == msp_pkg::CC_DATA_MSB || cc_num == msp_pkg::CC_DATA_LSB) begin
                           pval_in = pval_ff | shifted;
                           cmd_push = 1'b1;
                           cmd.event_action = msp_pkg::ACTION_SET;
                           cmd.event_value = pval_ff | shifted;
                        end
                     end
                  end
               end else if (held_next >= lim) begin
                  held_in = '0;
                  if (disc_en_ff) begin
                     cmd_push = 1'b1;
                     cmd.op = msp_pkg::CMD_RUN;
                     cmd.kind = msp_pkg::KIND_DISCARD;
                     cmd.count = held_next;
                  end
               end
            end
         end
         msp_pkg::F_FINISH: begin
            cmd_push = 1'b1;
            cmd.op = msp_pkg::CMD_RUN;
            cmd.kind = msp_pkg::KIND_MESSAGE;
            cmd.count = run_cnt_ff;
            state_in = msp_pkg::F_IDLE;
         end
         default: begin
            state_in = msp_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::F_IDLE;
         held_ff <= '0;
         buf0_ff <= '0;
         phase_ff <= 2'd0;
         pkind_ff <= 1'b0;
         pchan_ff <= 4'd0;
         pnum_ff <= 14'd0;
         pval_ff <= 14'd0;
         rs_en_ff <= 1'b0;
         trk_en_ff <= 1'b0;
         disc_en_ff <= 1'b0;
         max_len_ff <= 6'd32;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         buf0_ff <= buf0_in;
         phase_ff <= phase_in;
         pkind_ff <= pkind_in;
         pchan_ff <= pchan_in;
         pnum_ff <= pnum_in;
         pval_ff <= pval_in;
         if (csr_write) begin
            case (csr_index)
               msp_pkg::REG_RUNNING_STATUS: rs_en_ff <= csr_data[0];
               msp_pkg::REG_PARAM_TRACKING: trk_en_ff <= csr_data[0];
               msp_pkg::REG_DISCARD_REPORT: disc_en_ff <= csr_data[0];
               msp_pkg::REG_MAX_LENGTH: max_len_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      buf1_ff <= buf1_in;
      run_cnt_ff <= run_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_req.read_en) begin
         rd_data_ff <= mem[rd_req.read_addr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/msp_back.sv
// Result back end: executes queued commands and holds the result register.
`default_nettype none
module msp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_empty,
   input  wire msp_pkg::cmd_type     cmd,
   output logic                      cmd_pop,
   output logic                      idle,
   output msp_pkg::buf_read_type     rd_req,
   input  wire logic [7:0]           rd_data,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [1:0]                kind,
   output logic [7:0]                byte_value,
   output logic                      last,
   output logic [3:0]                event_channel,
   output logic                      event_type,
   output logic [1:0]                event_action,
   output logic [13:0]               event_parameter,
   output logic [13:0]               event_value
);
   msp_pkg::back_state_type state_ff, state_in;
   logic [msp_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [msp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] run_kind_ff, run_kind_in;
   logic       valid_ff, valid_in;
   msp_pkg::cmd_type out_ff, out_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       run_last;

   assign out_free = !valid_ff || pop;
   assign idle = (state_ff == msp_pkg::B_IDLE);
   assign run_last = (idx_ff + 1'b1) == cnt_ff;
   assign rd_req.read_en = (state_ff == msp_pkg::B_READ);
   assign rd_req.read_addr = idx_ff[msp_pkg::ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      run_kind_in = run_kind_ff;
      valid_in = valid_ff && !pop;
      out_in = out_ff;
      last_in = last_ff;
      cmd_pop = 1'b0;
      case (state_ff)
         msp_pkg::B_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.op == msp_pkg::CMD_RUN) begin
                  cmd_pop = 1'b1;
                  idx_in = '0;
                  cnt_in = cmd.count;
                  run_kind_in = cmd.kind;
                  state_in = msp_pkg::B_READ;
               end else if (out_free) begin
                  cmd_pop = 1'b1;
                  valid_in = 1'b1;
                  out_in = cmd;
                  last_in = (cmd.op == msp_pkg::CMD_SINGLE);
               end
            end
         end
         msp_pkg::B_READ: begin
            state_in = msp_pkg::B_DATA;
         end
         msp_pkg::B_DATA: begin
            if (out_free) begin
               valid_in = 1'b1;
               out_in = '0;
               out_in.kind = run_kind_ff;
               out_in.byte_value = rd_data;
               last_in = run_last;
               idx_in = idx_ff + 1'b1;
               state_in = run_last ? msp_pkg::B_IDLE : msp_pkg::B_READ;
            end
         end
         default: begin
            state_in = msp_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      run_kind_ff <= run_kind_in;
      out_ff <= out_in;
      last_ff <= last_in;
   end

   assign empty = !valid_ff;
   assign kind = out_ff.kind;
   assign byte_value = out_ff.byte_value;
   assign last = last_ff;
   assign event_channel = out_ff.event_channel;
   assign event_type = out_ff.event_type;
   assign event_action = out_ff.event_action;
   assign event_parameter = out_ff.event_parameter;
   assign event_value = out_ff.event_value;

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op == msp_pkg::CMD_RUN) |-> cmd.count != '0)
      else $error("empty run command");

   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msp_pkg::B_DATA) |-> idx_ff < cnt_ff)
      else $error("run index past count");
endmodule
`default_nettype wire

FILE: rtl/midi_stream_parser_nrpn_core.sv
// Top level of the MIDI byte stream parser with parameter-number event tracking.
// Requests enter through push/full, one received MIDI byte each; results leave
// through empty/pop, one message byte, discarded byte or parameter event each.
// Configuration is written through csr_write/csr_index/csr_data; the user must
// write it only while idle, which the block itself does not enforce. A front
// end frames bytes into a 32-byte message buffer and queues commands; a back
// end turns them into results through a one-entry result register. The front
// takes a new request only once the back end has drained all earlier commands,
// because runs are read from the buffer it writes. A stray byte that is
// dropped leaves the front idle; a stored byte first passes the store state.
// A buffered run leaves byte by byte through the registered buffer read, in a
// read and a data state per byte; single results and events need no such read.
// A real-time byte's result passes the command queue and the result register.
// Reset clears the held count, the tracker and the registers to defaults.
// Without pops, the back end holds and full stays high until it drains.
`default_nettype none
module midi_stream_parser_nrpn_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [7:0]                     req_data_byte,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [1:0]                          rsp_kind,
   output logic [7:0]                          rsp_byte_value,
   output logic                                rsp_last,
   output logic [3:0]                          rsp_event_channel,
   output logic                                rsp_event_type,
   output logic [1:0]                          rsp_event_action,
   output logic [13:0]                         rsp_event_parameter,
   output logic [13:0]                         rsp_event_value,
   input  wire logic                           csr_write,
   input  wire logic [msp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [msp_pkg::CSR_DATA_W-1:0] csr_data
);
   logic                  cmd_push;
   msp_pkg::cmd_type      cmd_in;
   msp_pkg::cmd_type      cmd_head;
   logic                  cmd_empty;
   logic                  cmd_pop;
   logic                  back_idle;
   logic                  drained;
   msp_pkg::buf_read_type rd_req;
   logic [7:0]            rd_data;

   assign drained = cmd_empty && back_idle;

   msp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .data_byte (req_data_byte),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .drained   (drained),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in),
      .rd_req    (rd_req),
      .rd_data   (rd_data)
   );

   msp_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .head     (cmd_head)
   );

   msp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (cmd_empty),
      .cmd             (cmd_head),
      .cmd_pop         (cmd_pop),
      .idle            (back_idle),
      .rd_req          (rd_req),
      .rd_data         (rd_data),
      .empty           (empty),
      .pop             (pop),
      .kind            (rsp_kind),
      .byte_value      (rsp_byte_value),
      .last            (rsp_last),
      .event_channel   (rsp_event_channel),
      .event_type      (rsp_event_type),
      .event_action    (rsp_event_action),
      .event_parameter (rsp_event_parameter),
      .event_value     (rsp_event_value)
   );
endmodule
`default_nettype wire
